// File: src/sliding_window_median_core_assert.svh
// Assertion macros used by the sliding window median top level.
`ifndef SLIDING_WINDOW_MEDIAN_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define SWM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swm: same-cycle check failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define SWM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swm: next-cycle check failed");

`endif

// File: src/swm_pkg.sv
// Shared constants and types for the sliding window median filter.
`default_nettype none

package swm_pkg;

    localparam int SWM_MAX_WINDOW  = 16;
    localparam int SWM_SAMPLE_BITS = 32;

    localparam int              CFG_LEN_W      = 5;
    localparam logic [CFG_LEN_W-1:0] WIN_LEN_RESET = 5'd16;

    // Broadcast control from the sequencer to every cell of the ring.
    typedef struct packed {
        logic load;
        logic run;
    } swm_cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } swm_state_t;

endpackage

`default_nettype wire

// File: src/swm_stream_ifs.sv
// Valid/ready stream interfaces for the sample input and the median output.
`default_nettype none

interface swm_sample_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface swm_median_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink (input valid, input median, output ready);
endinterface

`default_nettype wire

// File: src/swm_cell.sv
// One ring cell: holds a window entry and counts how many active entries rank below it.
`default_nettype none

module swm_cell
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = SWM_MAX_WINDOW,
    parameter int SAMPLE_BITS = SWM_SAMPLE_BITS,
    parameter int CELL_IDX    = 0,
    localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire swm_cell_ctl_t                 ctl,
    input  wire logic                          wr_sel,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic signed [SAMPLE_BITS-1:0] pass_in,
    input  wire logic [IDX_W-1:0]              step,
    input  wire logic [LEN_W-1:0]              len,
    input  wire logic [IDX_W-1:0]              target,
    output logic signed [SAMPLE_BITS-1:0]      own_value,
    output logic signed [SAMPLE_BITS-1:0]      pass_out,
    output logic                               is_median
);

    localparam logic [IDX_W:0] MY_IDX = (IDX_W+1)'(CELL_IDX);
    localparam logic [IDX_W:0] RING   = (IDX_W+1)'(MAX_WINDOW);

    logic signed [SAMPLE_BITS-1:0] own_reg,  own_next;
    logic signed [SAMPLE_BITS-1:0] pass_reg, pass_next;
    logic [IDX_W-1:0]              rank_reg, rank_next;

    logic [IDX_W:0] step_ext;
    logic [IDX_W:0] len_ext;
    logic [IDX_W:0] src_idx;
    logic           src_below;
    logic           count_hit;

    // After the load, the word in pass_reg at a given step came from the cell
    // that many places upstream in the ring.
    always_comb
    begin
        step_ext = {1'b0, step};
        len_ext  = (IDX_W+1)'(len);
        if (step_ext <= MY_IDX)
        begin
            src_idx = MY_IDX - step_ext;
        end
        else
        begin
            src_idx = MY_IDX + RING - step_ext;
        end
        // Ties are broken by ring position so that ranks form a permutation.
        src_below = (pass_reg < own_reg) || ((pass_reg == own_reg) && (src_idx < MY_IDX));
        count_hit = ctl.run && (src_idx < len_ext) && src_below;
    end

    always_comb
    begin
        if (ctl.load && wr_sel)
        begin
            own_next = sample;
        end
        else
        begin
            own_next = own_reg;
        end

        if (ctl.load)
        begin
            pass_next = own_next;
        end
        else if (ctl.run)
        begin
            pass_next = pass_in;
        end
        else
        begin
            pass_next = pass_reg;
        end

        if (ctl.load)
        begin
            rank_next = '0;
        end
        else if (count_hit)
        begin
            rank_next = rank_reg + 1'b1;
        end
        else
        begin
            rank_next = rank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg <= '0;
        end
        else
        begin
            own_reg <= own_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg <= pass_next;
        rank_reg <= rank_next;
    end

    assign own_value = own_reg;
    assign pass_out  = pass_reg;
    assign is_median = (MY_IDX < len_ext) && (rank_reg == target);

endmodule

`default_nettype wire

// File: src/sliding_window_median_core.sv
// Sliding window median filter top level: sequencer, cell ring and output register.
// Running median over the last window_len samples (1 to MAX_WINDOW, reset 16; zero
// acts as 1 and larger values saturate). Each accepted sample overwrites the oldest
// window entry and yields one median word, the entry of rank window_len/2 in signed
// ascending order (the upper median for even lengths). Reset clears the window to
// zero, and those zeros count as samples until overwritten. Each sample is accepted
// and loaded, then a copy of the window rotates once around the ring of cells while
// every cell counts the entries below its own, and then the cell whose count equals
// the target rank is picked into the output register once that register is free. No
// new sample is accepted until then. A finished median waits in the output register
// while the next sample is being worked on.
// Write window_len only while no sample is in flight.
`default_nettype none
`include "sliding_window_median_core_assert.svh"

module sliding_window_median_core
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = SWM_MAX_WINDOW,
    parameter int SAMPLE_BITS = SWM_SAMPLE_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_LEN_W-1:0] cfg_wdata,
    swm_sample_if.sink                samples,
    swm_median_if.source              medians
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_WINDOW - 1);

    swm_state_t state_reg, state_next;

    logic [CFG_LEN_W-1:0] win_len_reg,  win_len_next;
    logic [LEN_W-1:0]     len_run_reg,  len_run_next;
    logic [IDX_W-1:0]     oldest_reg,   oldest_next;
    logic [IDX_W-1:0]     step_reg,     step_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] median_reg, median_next;

    logic [LEN_W-1:0] len_eff;
    logic [IDX_W-1:0] slot;
    logic [IDX_W:0]   slot_inc;
    logic [IDX_W-1:0] target;
    logic             in_fire;
    logic             out_free;
    swm_cell_ctl_t    cell_ctl;

    logic signed [SAMPLE_BITS-1:0] own_arr  [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] pass_arr [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]         med_hit;
    logic signed [SAMPLE_BITS-1:0] sel_value;

    assign samples.ready = (state_reg == ST_IDLE);
    assign in_fire       = samples.valid && samples.ready;
    assign out_free      = !out_valid_reg || medians.ready;
    assign medians.valid  = out_valid_reg;
    assign medians.median = median_reg;

    assign cell_ctl.load = in_fire;
    assign cell_ctl.run  = (state_reg == ST_RUN);
    assign target        = IDX_W'(len_run_reg >> 1);

    always_comb
    begin
        if (win_len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(win_len_reg) > 32'(MAX_WINDOW))
        begin
            len_eff = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            len_eff = LEN_W'(win_len_reg);
        end
    end

    // A shortened window may leave the write pointer past its end; it wraps first.
    always_comb
    begin
        if ((IDX_W+1)'(oldest_reg) >= (IDX_W+1)'(len_eff))
        begin
            slot = '0;
        end
        else
        begin
            slot = oldest_reg;
        end
        slot_inc = (IDX_W+1)'(slot) + 1'b1;
    end

    always_comb
    begin
        sel_value = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            sel_value = sel_value | ({SAMPLE_BITS{med_hit[i]}} & own_arr[i]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        win_len_next   = win_len_reg;
        len_run_next   = len_run_reg;
        oldest_next    = oldest_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        median_next    = median_reg;

        if (cfg_we)
        begin
            win_len_next = cfg_wdata;
        end

        if (medians.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    len_run_next = len_eff;
                    step_next    = '0;
                    if (slot_inc >= (IDX_W+1)'(len_eff))
                    begin
                        oldest_next = '0;
                    end
                    else
                    begin
                        oldest_next = IDX_W'(slot_inc);
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    median_next    = sel_value;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_len_reg   <= WIN_LEN_RESET;
            len_run_reg   <= '0;
            oldest_reg    <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_len_reg   <= win_len_next;
            len_run_reg   <= len_run_next;
            oldest_reg    <= oldest_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
    end

    for (genvar g = 0; g < MAX_WINDOW; g++)
    begin : g_cell
        localparam int PREV = (g + MAX_WINDOW - 1) % MAX_WINDOW;

        swm_cell #(
            .MAX_WINDOW  (MAX_WINDOW),
            .SAMPLE_BITS (SAMPLE_BITS),
            .CELL_IDX    (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl),
            .wr_sel    (slot == IDX_W'(g)),
            .sample    (samples.sample),
            .pass_in   (pass_arr[PREV]),
            .step      (step_reg),
            .len       (len_run_reg),
            .target    (target),
            .own_value (own_arr[g]),
            .pass_out  (pass_arr[g]),
            .is_median (med_hit[g])
        );
    end

    // Ranks of the active cells form a permutation, so exactly one cell matches.
    `SWM_ASSERT_IMP(a_one_median, state_reg == ST_FINISH, $onehot(med_hit))
    // The write pointer always lands inside the window used for this sample.
    `SWM_ASSERT_NXT(a_slot_in_window, in_fire, (IDX_W+1)'(oldest_reg) < (IDX_W+1)'(len_run_reg))
    // A new median word appears only out of the finish step.
    `SWM_ASSERT_NXT(a_out_from_finish, (state_reg != ST_FINISH) && out_free, !out_valid_reg)

endmodule

`default_nettype wire

// File: tb/swm_median_checker.sv
// Checker for the sliding window median filter: predicts each median and compares it.
`timescale 1ns / 1ps

module swm_median_checker
    import swm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_LEN_W-1:0] cfg_wdata,
    swm_sample_if                samples,
    swm_median_if                medians,
    output int                   fail_count,
    output int                   pending
);

    localparam int SB = SWM_SAMPLE_BITS;
    localparam int REPORT_LIMIT = 10;

    logic signed [SB-1:0] win [SWM_MAX_WINDOW];
    logic [CFG_LEN_W-1:0] len_reg;
    int                   slot;
    logic signed [SB-1:0] medians_due [$];

    task automatic flag_failure(input string what, input logic signed [SB-1:0] want,
                                input logic signed [SB-1:0] got);
        if (fail_count < REPORT_LIMIT)
            $display("%0t: %s: expected %0d (0x%08h), got %0d (0x%08h)",
                     $realtime, what, want, want, got, got);
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict
        int n;
        int i;
        int k;
        int below;
        logic signed [SB-1:0] want;
        if (!rst_n)
        begin
            for (i = 0; i < SWM_MAX_WINDOW; i++)
                win[i] = '0;
            slot       = 0;
            len_reg    = WIN_LEN_RESET;
            fail_count = 0;
            medians_due.delete();
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
                len_reg = cfg_wdata;

            // A median word must match an expectation made on an earlier edge.
            if (medians.valid && medians.ready)
            begin
                if (medians_due.size() == 0)
                    flag_failure("median word with nothing expected", '0, medians.median);
                else
                begin
                    want = medians_due.pop_front();
                    if (medians.median !== want)
                        flag_failure("median mismatch", want, medians.median);
                end
            end

            if (samples.valid && samples.ready)
            begin
                if (len_reg == 0)
                    n = 1;
                else if (len_reg > SWM_MAX_WINDOW)
                    n = SWM_MAX_WINDOW;
                else
                    n = int'(len_reg);
                // A shortened window wraps the write position back to the start.
                if (slot >= n)
                    slot = 0;
                win[slot] = samples.sample;
                slot = (slot + 1 >= n) ? 0 : slot + 1;

                // Ties are broken by position, so exactly one entry holds each rank.
                want = '0;
                for (i = 0; i < n; i++)
                begin
                    below = 0;
                    for (k = 0; k < n; k++)
                        if (win[k] < win[i] || (win[k] == win[i] && k < i))
                            below++;
                    if (below == n / 2)
                        want = win[i];
                end
                medians_due.push_back(want);
            end
            pending = medians_due.size();
        end
    end

endmodule

// File: tb/tb_top.sv
// Top of the sliding window median testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top
    import swm_pkg::*;
();

    localparam int SB           = SWM_SAMPLE_BITS;
    localparam int RANDOM_ITEMS = 1300;
    localparam int DRAIN_CYCLES = SWM_MAX_WINDOW + 8;
    localparam int STALL_LIMIT  = 2000;

    localparam logic signed [SB-1:0] SMP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SB-1:0] SMP_MIN = 32'sh8000_0000;

    localparam logic [CFG_LEN_W-1:0] LEN_ZERO = 5'd0;
    localparam logic [CFG_LEN_W-1:0] LEN_ONE  = 5'd1;
    localparam logic [CFG_LEN_W-1:0] LEN_TWO  = 5'd2;
    localparam logic [CFG_LEN_W-1:0] LEN_SHORT = 5'd3;
    localparam logic [CFG_LEN_W-1:0] LEN_FULL = 5'd16;
    localparam logic [CFG_LEN_W-1:0] LEN_OVER = 5'd17;
    localparam logic [CFG_LEN_W-1:0] LEN_TOP  = 5'd31;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_LEN_W-1:0] cfg_wdata;
    bit                   calm;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles;
    int                   stall_left;

    swm_sample_if #(.SAMPLE_BITS(SB)) sample_ch ();
    swm_median_if #(.SAMPLE_BITS(SB)) median_ch ();

    sliding_window_median_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .samples   (sample_ch),
        .medians   (median_ch)
    );

    swm_median_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .samples    (sample_ch),
        .medians    (median_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            // Narrow range so that equal samples are common.
            4, 5:       return int'($urandom_range(0, 8)) - 4;
            6:
            begin
                case ($urandom_range(0, 4))
                    0:       return SMP_MAX;
                    1:       return SMP_MIN;
                    2:       return -1;
                    3:       return 0;
                    default: return 1;
                endcase
            end
            default:    return int'($urandom_range(0, 200 << 16)) - (100 << 16);
        endcase
    endfunction

    task automatic send_sample(input logic signed [SB-1:0] value);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        do @(posedge clk); while (!sample_ch.ready);
        @(negedge clk);
    endtask

    // The length register is only touched once every median word has come out.
    task automatic write_len(input logic [CFG_LEN_W-1:0] value);
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Receiver side: random stalls unless the current phase runs calm.
    initial
    begin
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                median_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                median_ch.ready <= 1'b1;
                if (!calm)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (median_ch.valid && median_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        int sent;
        int phase_items;
        logic [CFG_LEN_W-1:0] len_pick;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        calm             = 1'b0;
        idle_cycles      = 0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        median_ch.ready  = 1'b0;
        sent             = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Fresh window of 16: the reset zeros still take part in the median.
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(0);
        send_sample(-1);
        send_sample(1);
        send_sample(32'sh0001_0000);
        send_sample(32'shAAAA_AAAA);
        send_sample(32'sh5555_5555);

        // Shrinking below the write position wraps it to the start.
        write_len(LEN_SHORT);
        send_sample(5);
        send_sample(5);
        send_sample(-7);

        // Zero behaves as a window of one.
        write_len(LEN_ZERO);
        send_sample(SMP_MIN);
        send_sample(SMP_MAX);

        // Lengths above the store size saturate.
        write_len(LEN_TOP);
        send_sample(SMP_MIN);
        send_sample(SMP_MIN);
        send_sample(-2);
        send_sample(SMP_MAX);

        // Even length picks the upper of the two middle words.
        write_len(LEN_TWO);
        send_sample(-3);
        send_sample(3);
        send_sample(-3);

        write_len(LEN_ONE);
        send_sample(32'sh7FFF_0000);

        while (sent < RANDOM_ITEMS)
        begin
            phase_items = $urandom_range(20, 120);
            if ($urandom_range(0, 9) < 4)
            begin
                case ($urandom_range(0, 6))
                    0:       len_pick = LEN_ZERO;
                    1:       len_pick = LEN_ONE;
                    2:       len_pick = LEN_TWO;
                    3:       len_pick = LEN_FULL - 5'd1;
                    4:       len_pick = LEN_FULL;
                    5:       len_pick = LEN_OVER;
                    default: len_pick = LEN_TOP;
                endcase
            end
            else
                len_pick = CFG_LEN_W'($urandom_range(0, 31));
            write_len(len_pick);
            calm = ($urandom_range(0, 3) == 0);
            repeat (phase_items)
            begin
                send_sample(rand_sample());
                sent++;
            end
        end

        sample_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
